// ===== design/quaternion_rotate_vector_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion vector rotation block
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define QRV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication, disabled while reset is high
`define QRV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== design/qrv_pkg.sv =====
// ---------------------------------------------------------------------------
// qrv_pkg
// Widths, constants and the stage-enable bundle of the quaternion rotation
// pipeline.
// ---------------------------------------------------------------------------
package qrv_pkg;

   localparam int DATA_WIDTH  = 32;
   // quaternion products and rotation-matrix coefficients
   localparam int PROD_W      = 2 * DATA_WIDTH;
   localparam int COEF_W      = 2 * DATA_WIDTH + 2;
   // coefficient split for the multiplier: unsigned low half, signed high half
   localparam int LO_W        = COEF_W / 2;
   localparam int HI_W        = COEF_W - LO_W;
   localparam int PLO_W       = LO_W + 1 + DATA_WIDTH;
   localparam int PHI_W       = HI_W + DATA_WIDTH;
   // one coefficient times one vector component, and the sum of three
   localparam int TERM_W      = COEF_W + DATA_WIDTH;
   localparam int ACC_W       = TERM_W + 2;
   // quaternion fraction bits appear twice in each product
   localparam int ROUND_SHIFT = 2 * (DATA_WIDTH - 2);
   localparam int RND_W       = ACC_W - ROUND_SHIFT;

   localparam int NSTAGE      = 6;

   localparam logic signed [ACC_W-1:0] RND_HALF =
      ACC_W'(1) <<< (ROUND_SHIFT - 1);
   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // load enables of the per-row stages
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } qrv_stage_en_type;

endpackage

// ===== design/quaternion_rotate_vector.sv =====
// ---------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a Q16.16 vector by an unnormalized Q2.30 quaternion (q p q*),
// rounding once and saturating each component of the result.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | quat x,y,z,w and vec x,y,z
//  rsp     | out       | rsp_valid / rsp_ready  | rot x,y,z and saturated
//
//  One transaction enters per cycle while req_ready is high; its result
//  passes through one register stage after another: quaternion
//  products, rotation matrix, split 66 x 32 partial products, term merge,
//  three-term sum, round and saturate.
//  Reset clears only the stage valid bits.
//  A stage holds while its successor is full and stalled; empty stages
//  still fill, so req_ready stays high while any bubble remains.
// ---------------------------------------------------------------------------
`include "quaternion_rotate_vector_macros.svh"

module quaternion_rotate_vector (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   req_quat_x,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   req_quat_y,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   req_quat_z,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   req_quat_w,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   req_vec_x,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   req_vec_y,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   req_vec_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [qrv_pkg::DATA_WIDTH-1:0]   rsp_rot_x,
   output logic signed [qrv_pkg::DATA_WIDTH-1:0]   rsp_rot_y,
   output logic signed [qrv_pkg::DATA_WIDTH-1:0]   rsp_rot_z,
   output logic                                    rsp_saturated
);
   import qrv_pkg::*;

   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE:0]   rdy;
   qrv_stage_en_type  row_en;

   // stage 1: quaternion products
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PROD_W-1:0] xy_ff, xz_ff, yz_ff;
   logic signed [PROD_W-1:0] wx_ff, wy_ff, wz_ff;
   logic signed [DATA_WIDTH-1:0] vec1_ff [3];

   // stage 2: rotation matrix, scaled by |q|^2
   logic signed [COEF_W-1:0] coef_ff [3][3];
   logic signed [COEF_W-1:0] coef_in [3][3];
   logic signed [DATA_WIDTH-1:0] vec2_ff [3];

   logic signed [DATA_WIDTH-1:0] rot [3];
   logic [2:0]                   sat;

   function automatic logic signed [COEF_W-1:0] ext(input logic signed [PROD_W-1:0] p);
      return COEF_W'(p);
   endfunction

   // a stage can load when it is empty or its successor moves on
   always_comb begin
      rdy[NSTAGE] = rsp_ready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      vld_in = rdy[NSTAGE-1:0] & {vld_ff[NSTAGE-2:0], req_valid} |
               ~rdy[NSTAGE-1:0] & vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         xx_ff      <= req_quat_x * req_quat_x;
         yy_ff      <= req_quat_y * req_quat_y;
         zz_ff      <= req_quat_z * req_quat_z;
         ww_ff      <= req_quat_w * req_quat_w;
         xy_ff      <= req_quat_x * req_quat_y;
         xz_ff      <= req_quat_x * req_quat_z;
         yz_ff      <= req_quat_y * req_quat_z;
         wx_ff      <= req_quat_w * req_quat_x;
         wy_ff      <= req_quat_w * req_quat_y;
         wz_ff      <= req_quat_w * req_quat_z;
         vec1_ff[0] <= req_vec_x;
         vec1_ff[1] <= req_vec_y;
         vec1_ff[2] <= req_vec_z;
      end
   end

   always_comb begin
      coef_in[0][0] = ext(ww_ff) + ext(xx_ff) - ext(yy_ff) - ext(zz_ff);
      coef_in[0][1] = (ext(xy_ff) - ext(wz_ff)) <<< 1;
      coef_in[0][2] = (ext(xz_ff) + ext(wy_ff)) <<< 1;
      coef_in[1][0] = (ext(xy_ff) + ext(wz_ff)) <<< 1;
      coef_in[1][1] = ext(ww_ff) - ext(xx_ff) + ext(yy_ff) - ext(zz_ff);
      coef_in[1][2] = (ext(yz_ff) - ext(wx_ff)) <<< 1;
      coef_in[2][0] = (ext(xz_ff) - ext(wy_ff)) <<< 1;
      coef_in[2][1] = (ext(yz_ff) + ext(wx_ff)) <<< 1;
      coef_in[2][2] = ext(ww_ff) - ext(xx_ff) - ext(yy_ff) + ext(zz_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         coef_ff <= coef_in;
         vec2_ff <= vec1_ff;
      end
   end

   assign row_en.s3 = rdy[2];
   assign row_en.s4 = rdy[3];
   assign row_en.s5 = rdy[4];
   assign row_en.s6 = rdy[5];

   for (genvar r = 0; r < 3; r++) begin : g_row
      qrv_row u_row (
         .clock (clock),
         .en    (row_en),
         .coef0 (coef_ff[r][0]),
         .coef1 (coef_ff[r][1]),
         .coef2 (coef_ff[r][2]),
         .vec0  (vec2_ff[0]),
         .vec1  (vec2_ff[1]),
         .vec2  (vec2_ff[2]),
         .rot   (rot[r]),
         .sat   (sat[r])
      );
   end

   assign req_ready     = rdy[0];
   assign rsp_valid     = vld_ff[NSTAGE-1];
   assign rsp_rot_x     = rot[0];
   assign rsp_rot_y     = rot[1];
   assign rsp_rot_z     = rot[2];
   assign rsp_saturated = |sat;

   `QRV_ASSERT_IMP(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)
   `QRV_ASSERT_IMP(a_bubble_accepts, clock, reset, !(&vld_ff), req_ready)
   `QRV_ASSERT_NXT(a_coef_hold, clock, reset, vld_ff[1] && !rdy[1], $stable(coef_ff[0][0]))
   `QRV_ASSERT_IMP(a_sat_clamped, clock, reset, rsp_valid && rsp_saturated,
      rsp_rot_x == SAT_MAX || rsp_rot_x == SAT_MIN ||
      rsp_rot_y == SAT_MAX || rsp_rot_y == SAT_MIN ||
      rsp_rot_z == SAT_MAX || rsp_rot_z == SAT_MIN)

endmodule

// ===== design/qrv_row.sv =====
// ---------------------------------------------------------------------------
// qrv_row
// One row of the rotation matrix applied to the vector: split multiply,
// term merge, three-term sum with rounding bias, then round and saturate.
// ---------------------------------------------------------------------------
module qrv_row (
   input  logic                                    clock,
   input  qrv_pkg::qrv_stage_en_type               en,
   input  logic signed [qrv_pkg::COEF_W-1:0]       coef0,
   input  logic signed [qrv_pkg::COEF_W-1:0]       coef1,
   input  logic signed [qrv_pkg::COEF_W-1:0]       coef2,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   vec0,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   vec1,
   input  logic signed [qrv_pkg::DATA_WIDTH-1:0]   vec2,
   output logic signed [qrv_pkg::DATA_WIDTH-1:0]   rot,
   output logic                                    sat
);
   import qrv_pkg::*;

   logic signed [COEF_W-1:0]     coef [3];
   logic signed [DATA_WIDTH-1:0] vec  [3];

   logic signed [PLO_W-1:0]  plo_in  [3];
   logic signed [PLO_W-1:0]  plo_ff  [3];
   logic signed [PHI_W-1:0]  phi_in  [3];
   logic signed [PHI_W-1:0]  phi_ff  [3];
   logic signed [TERM_W-1:0] term_in [3];
   logic signed [TERM_W-1:0] term_ff [3];
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [RND_W-1:0]         rnd;
   logic [RND_W-DATA_WIDTH:0] head;
   logic                     fits;
   logic signed [DATA_WIDTH-1:0] rot_in;
   logic signed [DATA_WIDTH-1:0] rot_ff;
   logic                     sat_in;
   logic                     sat_ff;

   assign coef[0] = coef0;
   assign coef[1] = coef1;
   assign coef[2] = coef2;
   assign vec[0]  = vec0;
   assign vec[1]  = vec1;
   assign vec[2]  = vec2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         plo_in[i]  = $signed({1'b0, coef[i][LO_W-1:0]}) * vec[i];
         phi_in[i]  = $signed(coef[i][COEF_W-1:LO_W]) * vec[i];
         term_in[i] = (TERM_W'(phi_ff[i]) <<< LO_W) + TERM_W'(plo_ff[i]);
      end
   end

   assign acc_in = ACC_W'(term_ff[0]) + ACC_W'(term_ff[1]) + ACC_W'(term_ff[2]) + RND_HALF;

   // arithmetic shift by the fraction bits is just the upper slice
   assign rnd    = acc_ff[ACC_W-1:ROUND_SHIFT];
   assign head   = rnd[RND_W-1:DATA_WIDTH-1];
   assign fits   = (&head) || !(|head);
   assign rot_in = fits ? $signed(rnd[DATA_WIDTH-1:0]) :
                   (rnd[RND_W-1] ? SAT_MIN : SAT_MAX);
   assign sat_in = !fits;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (en.s4) begin
         term_ff <= term_in;
      end
      if (en.s5) begin
         acc_ff <= acc_in;
      end
      if (en.s6) begin
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign rot = rot_ff;
   assign sat = sat_ff;

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top - quaternion vector rotation bench
// Drives quaternion / vector pairs into quaternion_rotate_vector with random
// source gaps and sink stalls, predicts each rotated vector and saturation
// flag in exact 128-bit arithmetic, and checks every response in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int W  = qrv_pkg::DATA_WIDTH;
   localparam int AW = 128;
   localparam int RND_SHIFT = qrv_pkg::ROUND_SHIFT;
   localparam int STALL_LIMIT = 5000;

   typedef logic signed [W-1:0]  word_type;
   typedef logic signed [AW-1:0] wide_type;

   typedef struct {
      word_type rot_x;
      word_type rot_y;
      word_type rot_z;
      logic     saturated;
   } rotation_type;

   localparam wide_type ROUND_HALF = wide_type'(1) <<< (RND_SHIFT - 1);
   localparam wide_type OUT_MAX    = (wide_type'(1) <<< (W - 1)) - wide_type'(1);
   localparam wide_type OUT_MIN    = -(wide_type'(1) <<< (W - 1));
   localparam word_type ONE_Q30    = word_type'(1) <<< (W - 2);
   // sqrt(0.5) in Q2.30, for quarter turns
   localparam word_type HALF_ROOT  = word_type'(759250125);

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_quat_x = '0;
   word_type req_quat_y = '0;
   word_type req_quat_z = '0;
   word_type req_quat_w = '0;
   word_type req_vec_x = '0;
   word_type req_vec_y = '0;
   word_type req_vec_z = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b1;
   word_type rsp_rot_x;
   word_type rsp_rot_y;
   word_type rsp_rot_z;
   logic     rsp_saturated;

   rotation_type pending_rotations[$];
   int           error_count = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  sink_hold = 0;
   logic         src_idle_on = 1'b1;
   logic         sink_stall_on = 1'b1;

   quaternion_rotate_vector i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_quat_w    (req_quat_w),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rot_x     (rsp_rot_x),
      .rsp_rot_y     (rsp_rot_y),
      .rsp_rot_z     (rsp_rot_z),
      .rsp_saturated (rsp_saturated)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---- prediction --------------------------------------------------------

   function automatic word_type round_clamp(input wide_type acc, output logic clamped);
      wide_type rounded;
      rounded = (acc + ROUND_HALF) >>> RND_SHIFT;
      clamped = 1'b0;
      if (rounded > OUT_MAX) begin
         clamped = 1'b1;
         return qrv_pkg::SAT_MAX;
      end
      if (rounded < OUT_MIN) begin
         clamped = 1'b1;
         return qrv_pkg::SAT_MIN;
      end
      return word_type'(rounded);
   endfunction

   function automatic rotation_type predict_rotation(input word_type qx, qy, qz, qw,
                                                     input word_type vx, vy, vz);
      wide_type ux, uy, uz, uw, sx, sy, sz;
      wide_type xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
      wide_type c00, c01, c02, c10, c11, c12, c20, c21, c22;
      rotation_type r;
      logic clamp_x, clamp_y, clamp_z;
      ux = qx; uy = qy; uz = qz; uw = qw;
      sx = vx; sy = vy; sz = vz;
      xx = ux * ux; yy = uy * uy; zz = uz * uz; ww = uw * uw;
      xy = ux * uy; xz = ux * uz; yz = uy * uz;
      wx = uw * ux; wy = uw * uy; wz = uw * uz;
      // rotation matrix scaled by |q|^2
      c00 = ww + xx - yy - zz;
      c11 = ww - xx + yy - zz;
      c22 = ww - xx - yy + zz;
      c01 = (xy - wz) + (xy - wz);
      c10 = (xy + wz) + (xy + wz);
      c02 = (xz + wy) + (xz + wy);
      c20 = (xz - wy) + (xz - wy);
      c12 = (yz - wx) + (yz - wx);
      c21 = (yz + wx) + (yz + wx);
      r.rot_x = round_clamp(c00 * sx + c01 * sy + c02 * sz, clamp_x);
      r.rot_y = round_clamp(c10 * sx + c11 * sy + c12 * sz, clamp_y);
      r.rot_z = round_clamp(c20 * sx + c21 * sy + c22 * sz, clamp_z);
      r.saturated = clamp_x | clamp_y | clamp_z;
      return r;
   endfunction

   // ---- random helpers ----------------------------------------------------

   function automatic word_type rand_word();
      return word_type'({$urandom, $urandom});
   endfunction

   // signed value spanning the given number of bits
   function automatic word_type rand_span(input int bits);
      word_type v;
      v = rand_word();
      return v >>> (W - bits);
   endfunction

   function automatic word_type rand_special();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return qrv_pkg::SAT_MAX;
         2: return qrv_pkg::SAT_MIN;
         3: return ONE_Q30;
         4: return -ONE_Q30;
         5: return word_type'(1);
         6: return word_type'(-1);
         default: return rand_word();
      endcase
   endfunction

   // mostly zero or short, a few long
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---- source ------------------------------------------------------------

   // call right after a rising edge; returns at the edge that accepts
   task automatic send_rotation(input word_type qx, qy, qz, qw,
                                input word_type vx, vy, vz);
      int unsigned gap;
      gap = src_idle_on ? idle_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      req_quat_w <= qw;
      req_vec_x  <= vx;
      req_vec_y  <= vy;
      req_vec_z  <= vz;
      req_valid  <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // ---- sink --------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || !sink_stall_on) begin
         rsp_ready <= 1'b1;
         sink_hold <= 0;
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         sink_hold <= idle_length();
      end else begin
         rsp_ready <= 1'b1;
         sink_hold <= $urandom_range(0, 5);
      end
   end

   // ---- scoreboard --------------------------------------------------------

   task automatic check_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rotation_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_rotations.push_back(predict_rotation(req_quat_x, req_quat_y,
               req_quat_z, req_quat_w, req_vec_x, req_vec_y, req_vec_z));
         if (rsp_valid && rsp_ready) begin
            if (pending_rotations.size() == 0) begin
               $error("unexpected transaction: rot_x %0d rot_y %0d rot_z %0d sat %0b",
                      rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_saturated);
               error_count++;
            end else begin
               want = pending_rotations.pop_front();
               check_field("rot_x", want.rot_x, rsp_rot_x);
               check_field("rot_y", want.rot_y, rsp_rot_y);
               check_field("rot_z", want.rot_z, rsp_rot_z);
               check_field("saturated", word_type'(want.saturated),
                           word_type'(rsp_saturated));
            end
         end
      end
   end

   // ---- watchdog ----------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // ---- tests -------------------------------------------------------------

   task automatic test_identity();
      send_rotation('0, '0, '0, ONE_Q30, word_type'(65536), word_type'(-65536), '0);
      send_rotation('0, '0, '0, ONE_Q30, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MIN, word_type'(1));
      send_rotation('0, '0, '0, -ONE_Q30, word_type'(-1), rand_word(), rand_word());
   endtask

   task automatic test_zero_quaternion();
      send_rotation('0, '0, '0, '0, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MIN, rand_word());
      send_rotation('0, '0, '0, '0, rand_word(), rand_word(), rand_word());
   endtask

   task automatic test_quarter_turns();
      send_rotation(HALF_ROOT, '0, '0, HALF_ROOT, '0, word_type'(65536), '0);
      send_rotation('0, HALF_ROOT, '0, HALF_ROOT, '0, '0, word_type'(65536));
      send_rotation('0, '0, HALF_ROOT, HALF_ROOT, word_type'(65536), '0, '0);
   endtask

   // |q|^2 = 2^-30, so each output lands on or near half an LSB
   task automatic test_rounding_ties();
      word_type tie;
      tie = word_type'(1) <<< 29;
      send_rotation('0, '0, '0, word_type'(1) <<< 15, tie, -tie, tie * 3);
      send_rotation('0, '0, '0, word_type'(1) <<< 15, tie - 1, -tie - 1, -tie + 1);
   endtask

   task automatic test_saturation();
      send_rotation('0, '0, '0, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MIN, '0);
      send_rotation(qrv_pkg::SAT_MAX, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MAX,
                    qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN);
      send_rotation(qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN,
                    qrv_pkg::SAT_MAX, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MAX);
      send_rotation(qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN,
                    qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MIN);
      send_rotation(qrv_pkg::SAT_MAX, qrv_pkg::SAT_MIN, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MIN,
                    qrv_pkg::SAT_MIN, qrv_pkg::SAT_MAX, qrv_pkg::SAT_MIN);
   endtask

   task automatic send_random_rotation();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 40)
         send_rotation(rand_span(W - 1), rand_span(W - 1), rand_span(W - 1),
                       rand_span(W - 1), rand_span($urandom_range(4, W - 4)),
                       rand_span($urandom_range(4, W - 4)),
                       rand_span($urandom_range(4, W - 4)));
      else if (kind < 70)
         send_rotation(rand_word(), rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word());
      else if (kind < 85)
         send_rotation(rand_special(), rand_special(), rand_special(), rand_special(),
                       rand_special(), rand_special(), rand_special());
      else
         // large vectors drive the clamp often
         send_rotation(rand_span(W - 1), rand_span(W - 1), rand_span(W - 1),
                       rand_span(W - 1), rand_word(), rand_word(), rand_word());
   endtask

   // full-rate stretch: no source gaps, no sink stalls
   task automatic test_streaming(input int count);
      src_idle_on    = 1'b0;
      sink_stall_on <= 1'b0;
      repeat (count) send_random_rotation();
      src_idle_on    = 1'b1;
      sink_stall_on <= 1'b1;
   endtask

   task automatic test_random_stress(input int count);
      repeat (count) send_random_rotation();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_identity();
      test_zero_quaternion();
      test_quarter_turns();
      test_rounding_ties();
      test_saturation();
      test_streaming(60);
      test_random_stress(980);
      req_valid <= 1'b0;
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (2 * qrv_pkg::NSTAGE) @(posedge clock);
      if (error_count == 0 && pending_rotations.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
